@@ sv/adjacency_matrix_dfs_reachability_assert.svh @@
// Assertion macros for the adjacency matrix DFS reachability block.
// Depends on clk_i and rst_ni in the scope where the macros are used.
`ifndef ADJACENCY_MATRIX_DFS_REACHABILITY_ASSERT_SVH
`define ADJACENCY_MATRIX_DFS_REACHABILITY_ASSERT_SVH

`ifndef SYNTHESIS
`define AMDFS_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("amdfs: implication check failed");
`define AMDFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("amdfs: next-cycle check failed");
`else
`define AMDFS_ASSERT_IMPLIES(lbl, ante, cons)
`define AMDFS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ sv/amdfs_pkg.sv @@
// Shared types and constants for the adjacency matrix DFS reachability block.
// No dependencies.
package amdfs_pkg;

  localparam int unsigned VertexW = 6;
  localparam int unsigned RowW    = 64;
  localparam int unsigned CountW  = 7;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_EXPLORE = 4'b0010,
    ST_POPWAIT = 4'b0100,
    ST_DONE    = 4'b1000
  } state_e;

  typedef struct packed {
    logic               hit;
    logic [VertexW-1:0] idx;
  } pick_t;

endpackage

@@ sv/amdfs_pick.sv @@
// Neighbor picker: lowest unvisited, in-use neighbor of the current row.
// Depends on amdfs_pkg.
module amdfs_pick (
  input  logic [amdfs_pkg::RowW-1:0] row_i,
  input  logic [amdfs_pkg::RowW-1:0] mask_i,
  input  logic [amdfs_pkg::RowW-1:0] visited_i,
  output amdfs_pkg::pick_t           pick_o
);

  logic [amdfs_pkg::RowW-1:0]    open;
  logic [amdfs_pkg::RowW-1:0]    x;
  logic [amdfs_pkg::VertexW-1:0] idx;

  assign open = row_i & mask_i & ~visited_i;

  always_comb begin
    x   = open;
    idx = '0;
    for (int i = 0; i < amdfs_pkg::VertexW; i++) begin
      if ((x & ((64'd1 << (32 >> i)) - 64'd1)) == '0) begin
        idx = idx | amdfs_pkg::VertexW'(32 >> i);
        x   = x >> (32 >> i);
      end
    end
  end

  assign pick_o.hit = |open;
  assign pick_o.idx = idx;

endmodule

@@ sv/amdfs_adj_mem.sv @@
// Adjacency row memory with per-row valid bits; unwritten rows read as zero.
// Depends on amdfs_pkg.
module amdfs_adj_mem #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [amdfs_pkg::VertexW-1:0] waddr_i,
  input  logic [amdfs_pkg::RowW-1:0]    wdata_i,
  input  logic [amdfs_pkg::VertexW-1:0] raddr_i,
  output logic [amdfs_pkg::RowW-1:0]    rdata_o
);

  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam logic [amdfs_pkg::VertexW:0] MaxN = (amdfs_pkg::VertexW + 1)'(MAX_NODES);

  logic [amdfs_pkg::RowW-1:0] mem [MAX_NODES];
  logic [MAX_NODES-1:0]       valid_q;
  logic                       rd_ok_q;
  logic [amdfs_pkg::RowW-1:0] rd_data_q;
  logic                       w_in;
  logic                       r_in;
  logic [AW-1:0]              wa;
  logic [AW-1:0]              ra;

  assign w_in = {1'b0, waddr_i} < MaxN;
  assign r_in = {1'b0, raddr_i} < MaxN;
  assign wa   = waddr_i[AW-1:0];
  assign ra   = raddr_i[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (we_i && w_in) begin
        valid_q[wa] <= 1'b1;
      end
      rd_ok_q <= r_in && valid_q[ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && w_in) begin
      mem[wa] <= wdata_i;
    end
    rd_data_q <= mem[ra];
  end

  assign rdata_o = rd_ok_q ? rd_data_q : '0;

endmodule

@@ sv/amdfs_stack.sv @@
// Vertex stack memory: one write and one registered read per cycle.
// Depends on amdfs_pkg.
module amdfs_stack #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [$clog2(MAX_NODES)-1:0]         waddr_i,
  input  logic [amdfs_pkg::VertexW-1:0]        wdata_i,
  input  logic [$clog2(MAX_NODES)-1:0]         raddr_i,
  output logic [amdfs_pkg::VertexW-1:0]        rdata_o
);

  logic [amdfs_pkg::VertexW-1:0] mem [MAX_NODES];
  logic [amdfs_pkg::VertexW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_data_q <= mem[raddr_i];
  end

  assign rdata_o = rd_data_q;

endmodule

@@ sv/adjacency_matrix_dfs_reachability.sv @@
// Depth-first reachability over a loaded adjacency matrix. A load request
// writes one row. A search request starts from start_vertex, visits
// neighbors in ascending order and returns the reached set and its count.
// A vertex is pushed in ST_EXPLORE. Popping a vertex takes the stack
// memory read and then the adjacency memory read (via ST_POPWAIT), but
// popping the start vertex ends the search, and ST_DONE hands off the
// result. Input stays stalled while a search runs. The result waits in an
// output register; loads and new searches are still accepted.
// Depends on amdfs_pkg, amdfs_pick, amdfs_adj_mem, amdfs_stack and the
// assertion header.
`include "adjacency_matrix_dfs_reachability_assert.svh"

module adjacency_matrix_dfs_reachability #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [amdfs_pkg::CountW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [amdfs_pkg::VertexW-1:0] row_index_i,
  input  logic [amdfs_pkg::RowW-1:0]    row_bits_i,
  input  logic [amdfs_pkg::VertexW-1:0] start_vertex_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [amdfs_pkg::RowW-1:0]    reached_set_o,
  output logic [amdfs_pkg::CountW-1:0]  reached_count_o
);

  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam int unsigned DW = $clog2(MAX_NODES + 1);
  localparam logic [DW-1:0] MaxD = DW'(MAX_NODES);
  localparam logic [amdfs_pkg::CountW-1:0] MaxN = amdfs_pkg::CountW'(MAX_NODES);

  amdfs_pkg::state_e state_q, state_d;
  logic [DW-1:0]                 depth_q, depth_d;
  logic [amdfs_pkg::VertexW-1:0] top_q, top_d;
  logic [amdfs_pkg::RowW-1:0]    visited_q, visited_d;
  logic [amdfs_pkg::RowW-1:0]    mask_q, mask_d;
  logic [amdfs_pkg::CountW-1:0]  count_q, count_d;
  logic [amdfs_pkg::CountW-1:0]  node_count_q;
  logic                          out_valid_q, out_valid_d;
  logic [amdfs_pkg::RowW-1:0]    out_set_q;
  logic [amdfs_pkg::CountW-1:0]  out_count_q;

  logic                          in_acc;
  logic                          out_load;
  logic [amdfs_pkg::CountW-1:0]  active_n;
  logic [amdfs_pkg::RowW-1:0]    active_mask;
  logic [DW-1:0]                 depth_m2;

  logic                          adj_we;
  logic [amdfs_pkg::VertexW-1:0] adj_raddr;
  logic [amdfs_pkg::RowW-1:0]    adj_rdata;
  logic                          stk_we;
  logic [AW-1:0]                 stk_waddr;
  logic [amdfs_pkg::VertexW-1:0] stk_wdata;
  logic [amdfs_pkg::VertexW-1:0] stk_rdata;
  amdfs_pkg::pick_t              pick;
  logic                          push;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != amdfs_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == amdfs_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    active_n = node_count_q;
    if (active_n > MaxN) begin
      active_n = MaxN;
    end
    if (active_n == '0) begin
      active_n = amdfs_pkg::CountW'(1);
    end
    if (active_n >= amdfs_pkg::CountW'(amdfs_pkg::RowW)) begin
      active_mask = '1;
    end else begin
      active_mask = (64'd1 << active_n) - 64'd1;
    end
  end

  assign depth_m2 = depth_q - DW'(2);
  assign push     = pick.hit && (depth_q < MaxD);

  amdfs_pick u_pick (
    .row_i     (adj_rdata),
    .mask_i    (mask_q),
    .visited_i (visited_q),
    .pick_o    (pick)
  );

  amdfs_adj_mem #(
    .MAX_NODES (MAX_NODES)
  ) u_adj_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (adj_we),
    .waddr_i (row_index_i),
    .wdata_i (row_bits_i),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  amdfs_stack #(
    .MAX_NODES (MAX_NODES)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (depth_m2[AW-1:0]),
    .rdata_o (stk_rdata)
  );

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    top_d       = top_q;
    visited_d   = visited_q;
    mask_d      = mask_q;
    count_d     = count_q;
    adj_we      = 1'b0;
    adj_raddr   = start_vertex_i;
    stk_we      = 1'b0;
    stk_waddr   = depth_q[AW-1:0];
    stk_wdata   = pick.idx;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      amdfs_pkg::ST_IDLE: begin
        if (in_acc && (op_i == amdfs_pkg::OP_LOAD)) begin
          adj_we = 1'b1;
        end
        if (in_acc && (op_i == amdfs_pkg::OP_SEARCH)) begin
          visited_d = 64'd1 << start_vertex_i;
          top_d     = start_vertex_i;
          depth_d   = DW'(1);
          count_d   = amdfs_pkg::CountW'(1);
          mask_d    = active_mask;
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = start_vertex_i;
          state_d   = amdfs_pkg::ST_EXPLORE;
        end
      end
      amdfs_pkg::ST_EXPLORE: begin
        if (push) begin
          visited_d = visited_q | (64'd1 << pick.idx);
          top_d     = pick.idx;
          depth_d   = depth_q + DW'(1);
          count_d   = count_q + amdfs_pkg::CountW'(1);
          stk_we    = 1'b1;
          adj_raddr = pick.idx;
        end else begin
          depth_d = depth_q - DW'(1);
          if (depth_q == DW'(1)) begin
            state_d = amdfs_pkg::ST_DONE;
          end else begin
            state_d = amdfs_pkg::ST_POPWAIT;
          end
        end
      end
      amdfs_pkg::ST_POPWAIT: begin
        top_d     = stk_rdata;
        adj_raddr = stk_rdata;
        state_d   = amdfs_pkg::ST_EXPLORE;
      end
      amdfs_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = amdfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = amdfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= amdfs_pkg::ST_IDLE;
      depth_q      <= '0;
      node_count_q <= amdfs_pkg::CountW'(64);
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        node_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    visited_q <= visited_d;
    mask_q    <= mask_d;
    count_q   <= count_d;
    if (out_load) begin
      out_set_q   <= visited_q;
      out_count_q <= count_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign reached_set_o   = out_set_q;
  assign reached_count_o = out_count_q;

  `AMDFS_ASSERT_IMPLIES(a_depth_bound, 1'b1, depth_q <= MaxD)
  `AMDFS_ASSERT_IMPLIES(a_top_visited, state_q == amdfs_pkg::ST_EXPLORE, visited_q[top_q])
  `AMDFS_ASSERT_IMPLIES(a_count_match, state_q == amdfs_pkg::ST_DONE, count_q == amdfs_pkg::CountW'($countones(visited_q)))
  `AMDFS_ASSERT_NEXT(a_result_load, out_load, out_valid_q && (out_count_q == $past(count_q)))

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for adjacency_matrix_dfs_reachability: row loads and
// searches with random idling on both sides, checked against an internal DFS.
// Depends on amdfs_pkg and the adjacency_matrix_dfs_reachability RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_V = 64;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_AT = 350;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic                          op;
    logic [amdfs_pkg::VertexW-1:0] row_index;
    logic [amdfs_pkg::RowW-1:0]    row_bits;
    logic [amdfs_pkg::VertexW-1:0] start_vertex;
  } dfs_req_t;

  typedef struct {
    logic [amdfs_pkg::RowW-1:0]   reached_set;
    logic [amdfs_pkg::CountW-1:0] reached_count;
  } reach_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [amdfs_pkg::CountW-1:0]  cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic                          op_i = amdfs_pkg::OP_LOAD;
  logic [amdfs_pkg::VertexW-1:0] row_index_i = '0;
  logic [amdfs_pkg::RowW-1:0]    row_bits_i = '0;
  logic [amdfs_pkg::VertexW-1:0] start_vertex_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [amdfs_pkg::RowW-1:0]    reached_set_o;
  logic [amdfs_pkg::CountW-1:0]  reached_count_o;

  logic [amdfs_pkg::RowW-1:0]   adj_rows [MAX_V] = '{default: '0};
  logic [amdfs_pkg::CountW-1:0] node_count_q = amdfs_pkg::CountW'(64);

  dfs_req_t req_q [$];
  reach_t   reach_q [$];
  dfs_req_t cur_req;

  int  errors = 0;
  int  accepted_cnt = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  quiet = 1'b0;

  adjacency_matrix_dfs_reachability u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .row_index_i    (row_index_i),
    .row_bits_i     (row_bits_i),
    .start_vertex_i (start_vertex_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .reached_set_o  (reached_set_o),
    .reached_count_o(reached_count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int active_nodes();
    int n;
    n = node_count_q;
    if (n > MAX_V) n = MAX_V;
    if (n == 0) n = 1;
    return n;
  endfunction

  function automatic reach_t dfs_reach(input logic [amdfs_pkg::VertexW-1:0] start);
    logic [amdfs_pkg::RowW-1:0]    mask;
    logic [amdfs_pkg::RowW-1:0]    visited;
    logic [amdfs_pkg::RowW-1:0]    open;
    logic [amdfs_pkg::VertexW-1:0] stack [MAX_V];
    int                            depth;
    int                            n;
    int                            nxt;
    reach_t                        r;
    n = active_nodes();
    mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    visited = 64'd1 << start;
    stack[0] = start;
    depth = 1;
    while (depth > 0) begin
      open = adj_rows[stack[depth-1]] & mask & ~visited;
      if (open != '0 && depth < MAX_V) begin
        nxt = 0;
        while (!open[nxt]) nxt++;
        visited[nxt] = 1'b1;
        stack[depth] = nxt[amdfs_pkg::VertexW-1:0];
        depth++;
      end else begin
        depth--;
      end
    end
    r.reached_set = visited;
    r.reached_count = amdfs_pkg::CountW'($countones(visited));
    return r;
  endfunction

  function automatic logic [amdfs_pkg::RowW-1:0] rand_row();
    logic [amdfs_pkg::RowW-1:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: r = '0;
      1: r = '1;
      2: ;
      3: r = 64'd1 << $urandom_range(0, 63);
      4: r = r & {$urandom, $urandom} & {$urandom, $urandom};
      default: r = (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
    endcase
    return r;
  endfunction

  function automatic dfs_req_t load_req(input int idx,
                                        input logic [amdfs_pkg::RowW-1:0] bits);
    dfs_req_t r;
    r.op = amdfs_pkg::OP_LOAD;
    r.row_index = idx[amdfs_pkg::VertexW-1:0];
    r.row_bits = bits;
    r.start_vertex = amdfs_pkg::VertexW'($urandom_range(0, 63));
    return r;
  endfunction

  function automatic dfs_req_t search_req(input int start);
    dfs_req_t r;
    r.op = amdfs_pkg::OP_SEARCH;
    r.row_index = amdfs_pkg::VertexW'($urandom_range(0, 63));
    r.row_bits = {$urandom, $urandom};
    r.start_vertex = start[amdfs_pkg::VertexW-1:0];
    return r;
  endfunction

  // Driver: present queued requests, hold while stalled, idle in bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        accepted_cnt <= accepted_cnt + 1;
        if (op_i == amdfs_pkg::OP_LOAD) begin
          adj_rows[row_index_i] = row_bits_i;
        end else begin
          reach_q.push_back(dfs_reach(start_vertex_i));
        end
      end
      if (in_valid_i && in_stall_o) begin
      end else if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (req_q.size() != 0) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          in_valid_i <= 1'b0;
          send_gap <= $urandom_range(0, 8);
        end else begin
          cur_req = req_q.pop_front();
          in_valid_i <= 1'b1;
          op_i <= cur_req.op;
          row_index_i <= cur_req.row_index;
          row_bits_i <= cur_req.row_bits;
          start_vertex_i <= cur_req.start_vertex;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, once, while the sender keeps offering requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each accepted result against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    reach_t exp_r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (reach_q.size() == 0) begin
          $error("unexpected result: reached_set %h reached_count %0d",
                 reached_set_o, reached_count_o);
          errors++;
        end else begin
          exp_r = reach_q.pop_front();
          if (reached_set_o !== exp_r.reached_set) begin
            $error("reached_set: expected %h, actual %h", exp_r.reached_set, reached_set_o);
            errors++;
          end
          if (reached_count_o !== exp_r.reached_count) begin
            $error("reached_count: expected %0d, actual %0d",
                   exp_r.reached_count, reached_count_o);
            errors++;
          end
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
      end else if (recv_gap != 0) begin
        out_stall_i <= 1'b1;
        recv_gap <= recv_gap - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        recv_gap <= $urandom_range(0, 8);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic wait_drained(input int extra);
    do @(negedge clk_i);
    while (req_q.size() != 0 || in_valid_i || reach_q.size() != 0);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_count(input logic [amdfs_pkg::CountW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    node_count_q = value;
    @(negedge clk_i);
  endtask

  task automatic run_random(input int count);
    int n;
    int pushed;
    int k;
    int i;
    n = active_nodes();
    pushed = 0;
    while (pushed < count) begin
      k = $urandom_range(0, 19);
      if (k < 12) begin
        repeat ($urandom_range(1, (n < 8) ? n : 8)) begin
          if ($urandom_range(0, 4) == 0) i = $urandom_range(0, 63);
          else i = $urandom_range(0, n - 1);
          req_q.push_back(load_req(i, rand_row()));
          pushed++;
        end
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 5) == 0) i = $urandom_range(0, 63);
          else i = $urandom_range(0, n - 1);
          req_q.push_back(search_req(i));
          pushed++;
        end
      end else if (k < 15) begin
        for (i = 0; i < n; i++) begin
          req_q.push_back(load_req(i, (64'd1 << (i + 1)) |
                                      (($urandom_range(0, 3) == 0) ? rand_row() : '0)));
        end
        req_q.push_back(search_req(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 63)));
        pushed += n + 1;
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          req_q.push_back(load_req($urandom_range(0, 63), rand_row()));
        end else begin
          req_q.push_back(search_req($urandom_range(0, 63)));
        end
        pushed++;
      end
    end
  endtask

  initial begin
    int phase_counts [9];
    int p;
    phase_counts = '{64, 2, 65, 13, 40, 0, 1, 63, 64};
    phase_counts[5] = $urandom_range(0, 127);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    req_q.push_back(search_req(0));
    req_q.push_back(search_req(63));
    req_q.push_back(load_req(0, '1));
    req_q.push_back(search_req(0));
    req_q.push_back(load_req(0, 64'd1 << 63));
    req_q.push_back(load_req(63, 64'd1));
    req_q.push_back(search_req(63));
    req_q.push_back(search_req(0));
    wait_drained(DRAIN_CYCLES);

    write_count(amdfs_pkg::CountW'(1));
    req_q.push_back(load_req(5, '1));
    req_q.push_back(search_req(5));
    req_q.push_back(search_req(0));
    req_q.push_back(search_req(63));
    wait_drained(DRAIN_CYCLES);

    write_count(amdfs_pkg::CountW'(0));
    req_q.push_back(search_req(5));
    req_q.push_back(search_req(63));
    wait_drained(DRAIN_CYCLES);

    write_count(amdfs_pkg::CountW'(127));
    req_q.push_back(search_req(5));
    req_q.push_back(load_req(5, '0));
    req_q.push_back(search_req(5));
    wait_drained(DRAIN_CYCLES);

    for (p = 0; p < 9; p++) begin
      write_count(amdfs_pkg::CountW'(phase_counts[p]));
      run_random(25);
      wait_drained(0);
      if (p == 8) quiet = 1'b1;
      run_random(25);
      wait_drained(DRAIN_CYCLES);
    end

    if (errors == 0 && reach_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(64'd20_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule
